// File: rtl/core/eflca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the free-list chunk allocator.
// No dependencies.

package eflca_pkg;

    typedef logic [1:0] op_t;
    typedef logic [7:0] unit_t;

    localparam op_t OP_FORMAT  = 2'd0;
    localparam op_t OP_REQUEST = 2'd1;
    localparam op_t OP_RELEASE = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam unit_t UNIT_MAX = 8'hFF;

endpackage

// File: rtl/core/embedded_free_list_chunk_allocator.sv
`timescale 1ns / 1ps
// Single-frame chunk allocator: free list threaded through a link memory.
// Depends on eflca_pkg.
// Release, null request, unused code and a format that fits no chunk finish from
// IDLE; a request reads the head's link in ST_REQ; a format writes links in ST_FMT,
// through the single write port of the link memory, one link per cycle.
// One item at a time; busy stays high until the done strobe is due.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset: empty free list (frame full), no units allocated, chunk size 1;
// link memory contents are left as they are.

module embedded_free_list_chunk_allocator #(
    parameter int UNIT_COUNT = 240
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           operation,
    input  logic [7:0]           chunk_index,
    input  logic                 chunk_units_we,
    input  logic [7:0]           chunk_units,
    output logic                 done,
    output logic                 status,
    output logic [7:0]           granted_index,
    output logic                 frame_empty,
    output logic                 frame_full,
    output logic [7:0]           allocated_units
);

    localparam int IDX_W = $clog2(UNIT_COUNT);
    localparam logic [9:0] UNIT_LIMIT = 10'(UNIT_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_REQ  = 2'd1;
    localparam logic [1:0] ST_FMT  = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    eflca_pkg::unit_t      head_reg;
    eflca_pkg::unit_t      head_next;
    eflca_pkg::unit_t      used_reg;
    eflca_pkg::unit_t      used_next;
    eflca_pkg::unit_t      stride_reg;
    eflca_pkg::unit_t      stride_next;
    eflca_pkg::unit_t      chunk_units_reg;
    logic [9:0]            pos_reg;
    logic [9:0]            pos_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  status_reg;
    logic                  status_next;
    eflca_pkg::unit_t      granted_reg;
    eflca_pkg::unit_t      granted_next;

    eflca_pkg::unit_t      link_mem [UNIT_COUNT];
    eflca_pkg::unit_t      rdata_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    eflca_pkg::unit_t      mem_wdata;

    logic                  accept;
    eflca_pkg::unit_t      fmt_stride;
    logic [9:0]            fmt_next_pos;
    logic                  fmt_more;
    logic                  head_bad;
    logic                  idx_ok;
    logic [8:0]            used_sum;

    assign accept       = start && (state_reg == ST_IDLE);
    assign fmt_stride   = (chunk_units_reg == 8'd0) ? 8'd1 : chunk_units_reg;
    assign fmt_next_pos = pos_reg + {2'b00, stride_reg};
    assign fmt_more     = (fmt_next_pos + {2'b00, stride_reg}) <= UNIT_LIMIT;
    assign head_bad     = (head_reg == 8'd0) || ({2'b00, head_reg} >= UNIT_LIMIT);
    assign idx_ok       = (chunk_index != 8'd0) && ({2'b00, chunk_index} < UNIT_LIMIT);
    assign used_sum     = {1'b0, used_reg} + {1'b0, stride_reg};

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        stride_next  = stride_reg;
        pos_next     = pos_reg;
        done_next    = 1'b0;
        status_next  = eflca_pkg::STATUS_OK;
        granted_next = 8'd0;
        mem_we       = 1'b0;
        mem_waddr    = chunk_index[IDX_W-1:0];
        mem_wdata    = head_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        eflca_pkg::OP_FORMAT:
                        begin
                            stride_next = fmt_stride;
                            used_next   = 8'd0;
                            pos_next    = 10'd1;
                            if ((10'd1 + {2'b00, fmt_stride}) <= UNIT_LIMIT)
                            begin
                                head_next  = 8'd1;
                                state_next = ST_FMT;
                            end
                            else
                            begin
                                head_next = 8'd0;
                                done_next = 1'b1;
                            end
                        end
                        eflca_pkg::OP_REQUEST:
                        begin
                            if (head_bad)
                            begin
                                status_next = eflca_pkg::STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                // link of the head is read at this edge
                                state_next = ST_REQ;
                            end
                        end
                        eflca_pkg::OP_RELEASE:
                        begin
                            done_next = 1'b1;
                            if (idx_ok)
                            begin
                                mem_we    = 1'b1;
                                head_next = chunk_index;
                                used_next = (used_reg > stride_reg) ?
                                            (used_reg - stride_reg) : 8'd0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_REQ:
            begin
                granted_next = head_reg;
                head_next    = rdata_reg;
                used_next    = used_sum[8] ? eflca_pkg::UNIT_MAX : used_sum[7:0];
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_FMT:
            begin
                // write one link per cycle; the last chunk ends the list
                mem_we    = 1'b1;
                mem_waddr = pos_reg[IDX_W-1:0];
                mem_wdata = fmt_more ? fmt_next_pos[7:0] : 8'd0;
                if (fmt_more)
                begin
                    pos_next = fmt_next_pos;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= 8'd0;
            used_reg        <= 8'd0;
            stride_reg      <= 8'd1;
            chunk_units_reg <= 8'd1;
            pos_reg         <= 10'd1;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            used_reg   <= used_next;
            stride_reg <= stride_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
            if (chunk_units_we)
            begin
                chunk_units_reg <= chunk_units;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[head_reg[IDX_W-1:0]];
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_index   = granted_reg;
    assign frame_empty     = (used_reg == 8'd0);
    assign frame_full      = (head_reg == 8'd0);
    assign allocated_units = used_reg;

endmodule

// File: tb/tb_embedded_free_list_chunk_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the free-list chunk allocator.
// Depends on eflca_pkg and embedded_free_list_chunk_allocator.

module tb_embedded_free_list_chunk_allocator;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int UNIT_COUNT  = 240;
    localparam eflca_pkg::op_t OP_UNUSED = 2'd3;

    typedef struct {
        eflca_pkg::op_t   op;
        eflca_pkg::unit_t idx;
    } alloc_cmd_t;

    typedef struct {
        logic             status;
        eflca_pkg::unit_t granted;
        logic             empty;
        logic             full;
        eflca_pkg::unit_t used;
    } alloc_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = OP_UNUSED;
    logic [7:0]  chunk_index = 8'd0;
    logic        chunk_units_we = 1'b0;
    logic [7:0]  chunk_units = 8'd1;
    logic        done;
    logic        status;
    logic [7:0]  granted_index;
    logic        frame_empty;
    logic        frame_full;
    logic [7:0]  allocated_units;

    alloc_cmd_t    cmd_backlog[$];
    alloc_result_t alloc_outcomes[$];
    int            send_gap_pct = 0;
    int            error_count = 0;
    int            result_count = 0;
    int            cycle_count = 0;

    // predictor copy of the allocator state
    eflca_pkg::unit_t link_mem[UNIT_COUNT];
    eflca_pkg::unit_t head_unit = 8'd0;
    eflca_pkg::unit_t used_cnt = 8'd0;
    eflca_pkg::unit_t stride_cnt = 8'd1;
    eflca_pkg::unit_t chunk_cfg = 8'd1;

    embedded_free_list_chunk_allocator #(
        .UNIT_COUNT(UNIT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .chunk_index(chunk_index),
        .chunk_units_we(chunk_units_we),
        .chunk_units(chunk_units),
        .done(done),
        .status(status),
        .granted_index(granted_index),
        .frame_empty(frame_empty),
        .frame_full(frame_full),
        .allocated_units(allocated_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic alloc_result_t predict_allocation(alloc_cmd_t cmd);
        alloc_result_t res;
        int s;
        int pos;
        int prev;
        int sum;
        res.status  = eflca_pkg::STATUS_OK;
        res.granted = 8'd0;
        case (cmd.op)
            eflca_pkg::OP_FORMAT:
            begin
                s = (chunk_cfg == 8'd0) ? 1 : int'(chunk_cfg);
                stride_cnt = eflca_pkg::unit_t'(s);
                foreach (link_mem[i]) link_mem[i] = 8'd0;
                head_unit = 8'd0;
                pos = 1;
                prev = 0;
                // thread only chunks that end inside the frame
                while (pos + s <= UNIT_COUNT)
                begin
                    if (prev == 0)
                        head_unit = eflca_pkg::unit_t'(pos);
                    else
                        link_mem[prev] = eflca_pkg::unit_t'(pos);
                    prev = pos;
                    pos += s;
                end
                used_cnt = 8'd0;
            end
            eflca_pkg::OP_REQUEST:
            begin
                if (head_unit == 8'd0 || head_unit >= UNIT_COUNT)
                    res.status = eflca_pkg::STATUS_FULL;
                else
                begin
                    res.granted = head_unit;
                    head_unit = link_mem[head_unit];
                    sum = int'(used_cnt) + int'(stride_cnt);
                    used_cnt = (sum > 255) ? eflca_pkg::UNIT_MAX : eflca_pkg::unit_t'(sum);
                end
            end
            eflca_pkg::OP_RELEASE:
            begin
                if (cmd.idx != 8'd0 && cmd.idx < UNIT_COUNT)
                begin
                    link_mem[cmd.idx] = head_unit;
                    head_unit = cmd.idx;
                    used_cnt = (used_cnt > stride_cnt) ? used_cnt - stride_cnt : 8'd0;
                end
            end
            default:
            begin
            end
        endcase
        res.empty = (used_cnt == 8'd0);
        res.full  = (head_unit == 8'd0);
        res.used  = used_cnt;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (error_count < 40)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, result_count, field, got, want);
        error_count++;
    endtask

    // driver: present the oldest pending command, hold it until the transfer
    always @(posedge clk)
    begin
        bit taken;
        bit present;
        taken = start && !busy;
        if (taken)
        begin
            alloc_outcomes.push_back(predict_allocation(cmd_backlog[0]));
            void'(cmd_backlog.pop_front());
        end
        if (start && !taken)
            present = 1'b1;
        else
            present = rst_n && (cmd_backlog.size() != 0) &&
                      ($urandom_range(99, 0) >= send_gap_pct);
        start <= present;
        if (present)
        begin
            operation   <= cmd_backlog[0].op;
            chunk_index <= cmd_backlog[0].idx;
        end
    end

    // monitor: one result per done strobe, compared against the oldest outcome
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (alloc_outcomes.size() == 0)
                report_mismatch("unexpected result, status", status, 0);
            else
            begin
                want = alloc_outcomes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (granted_index !== want.granted)
                    report_mismatch("granted_index", granted_index, want.granted);
                if (frame_empty !== want.empty)
                    report_mismatch("frame_empty", frame_empty, want.empty);
                if (frame_full !== want.full)
                    report_mismatch("frame_full", frame_full, want.full);
                if (allocated_units !== want.used)
                    report_mismatch("allocated_units", allocated_units, want.used);
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_cmd(input eflca_pkg::op_t op, input eflca_pkg::unit_t idx);
        alloc_cmd_t cmd;
        cmd.op  = op;
        cmd.idx = idx;
        cmd_backlog.push_back(cmd);
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || alloc_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_chunk_units(input int value);
        wait_idle();
        @(posedge clk);
        chunk_units_we <= 1'b1;
        chunk_units    <= eflca_pkg::unit_t'(value);
        chunk_cfg = eflca_pkg::unit_t'(value);
        @(posedge clk);
        chunk_units_we <= 1'b0;
    endtask

    // one random run: format, then request and release bursts (aligned where a chunk fits) and single ops
    task automatic random_segment(input int seg);
        int cu;
        int s;
        int nfit;
        int made;
        int r;
        int run;
        int k;
        r = $urandom_range(99, 0);
        if (seg == 0)
            cu = 1;
        else if (seg == 1)
            cu = 239;
        else if (r < 10)
            cu = (r < 5) ? 0 : 255;
        else if (r < 60)
            cu = $urandom_range(8, 1);
        else
            cu = $urandom_range(239, 1);
        set_chunk_units(cu);
        s = (cu == 0) ? 1 : cu;
        nfit = (s < UNIT_COUNT) ? (UNIT_COUNT - 1 - s) / s + 1 : 0;
        queue_cmd(eflca_pkg::OP_FORMAT, eflca_pkg::unit_t'($urandom));
        made = 1;
        while (made < 100)
        begin
            r = $urandom_range(99, 0);
            if (r < 40)
            begin
                run = $urandom_range(((nfit > 60) ? 60 : nfit) + 3, 1);
                repeat (run) queue_cmd(eflca_pkg::OP_REQUEST, eflca_pkg::unit_t'($urandom));
            end
            else if (r < 75)
            begin
                run = $urandom_range(20, 1);
                repeat (run)
                begin
                    if (nfit > 0)
                        k = 1 + s * $urandom_range(nfit - 1, 0);
                    else
                        k = $urandom_range(UNIT_COUNT - 1, 1);
                    queue_cmd(eflca_pkg::OP_RELEASE, eflca_pkg::unit_t'(k));
                end
            end
            else if (r < 94)
            begin
                run = 1;
                queue_cmd(eflca_pkg::op_t'($urandom_range(3, 0)),
                          eflca_pkg::unit_t'($urandom));
            end
            else
            begin
                run = 1;
                queue_cmd(eflca_pkg::OP_FORMAT, eflca_pkg::unit_t'($urandom));
            end
            made += run;
        end
    endtask

    initial
    begin
        foreach (link_mem[i]) link_mem[i] = 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state: empty free list, ignored out-of-range releases, unused code, accepted release of unit 239
        send_gap_pct = 7;
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(OP_UNUSED, 8'hFF);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd0);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd240);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd255);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd239);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);

        // zero chunk size formats as one unit; double release and release of a unit never granted
        set_chunk_units(0);
        queue_cmd(eflca_pkg::OP_FORMAT, 8'hFF);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd1);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd1);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd100);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);

        // no chunk fits the frame
        set_chunk_units(255);
        queue_cmd(eflca_pkg::OP_FORMAT, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);

        // single largest chunk; a looped list drives the counter to saturation
        set_chunk_units(239);
        queue_cmd(eflca_pkg::OP_FORMAT, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd1);
        queue_cmd(eflca_pkg::OP_RELEASE, 8'd1);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);
        queue_cmd(eflca_pkg::OP_REQUEST, 8'd0);

        for (int seg = 0; seg < 10; seg++)
        begin
            wait_idle();
            send_gap_pct = (seg < 4) ? 7 : (seg < 7) ? 71 : 0;
            random_segment(seg);
        end

        wait_idle();
        repeat (UNIT_COUNT + 8) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
